// ===== design/dsfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfs_pkg
// Shared types, constants and the phasor table of the dual-sideband shifter.
// ----------------------------------------------------------------------------
package dsfs_pkg;

    localparam int PERIOD   = 64;   // phasor table length
    localparam int PHASE_W  = 6;    // bits of the phase index
    localparam int SAMPLE_W = 16;   // Q1.15 sample width
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int QTR      = PERIOD / 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t re;
        sample_t im;
    } cplx_t;

    typedef struct packed {
        sample_t cos_v;
        sample_t sin_v;
    } phasor_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // |sin(j*pi/32)| in Q1.15 for j = 0..16, full scale clipped to 32767
    localparam logic [SAMPLE_W-2:0] SIN_MAG [QTR+1] = '{
        15'd0,     15'd3212,  15'd6393,  15'd9512,
        15'd12540, 15'd15447, 15'd18205, 15'd20788,
        15'd23170, 15'd25330, 15'd27246, 15'd28899,
        15'd30274, 15'd31357, 15'd32138, 15'd32610,
        15'd32767
    };

    // cos/sin of 2*pi*idx/PERIOD, first-quadrant value rotated into place
    function automatic phasor_t phasor_lookup(input logic [PHASE_W-1:0] idx);
        logic [4:0]    j;
        sample_t       s_q;
        sample_t       c_q;
        phasor_t       ph;
        j   = {1'b0, idx[3:0]};
        s_q = sample_t'({1'b0, SIN_MAG[j]});
        c_q = sample_t'({1'b0, SIN_MAG[5'(QTR) - j]});
        unique case (quad_t'(idx[5:4]))
            QUAD_0: begin
                ph.cos_v = c_q;
                ph.sin_v = s_q;
            end
            QUAD_1: begin
                ph.cos_v = -s_q;
                ph.sin_v = c_q;
            end
            QUAD_2: begin
                ph.cos_v = -c_q;
                ph.sin_v = -s_q;
            end
            default: begin
                ph.cos_v = s_q;
                ph.sin_v = -c_q;
            end
        endcase
        return ph;
    endfunction

    // Q3.30 -> Q1.15, round half up, saturate
    function automatic sample_t round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0]           biased;
        logic signed [SUM_W-SAMPLE_W+2:0] q;
        sample_t                         r;
        biased = {v[SUM_W-1], v} + (SUM_W+1)'(16384);
        q      = {biased[SUM_W], biased[SUM_W:SAMPLE_W-1]};
        if (q > (SUM_W-SAMPLE_W+3)'(32767)) begin
            r = 16'sh7FFF;
        end else if (q < -(SUM_W-SAMPLE_W+3)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/dual_sideband_frequency_shifter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_sideband_frequency_shifter
// Mixes each complex sample with a 64-step phasor, both rotation senses.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one complex Q1.15 sample per transaction.
//   m_ channel: one transaction per sample with the up-shifted product
//               (x * (c+js)) and the down-shifted product (x * (c-js)),
//               each part rounded half up and saturated to 16 bits.
//   The phasor steps by 2*pi/64 per accepted sample, wrapping after 64.
// Path: each sample goes through the input register, then multiply/round
//   into the result register, which drives m_tvalid.
// Throughput: one sample per clock while m_tready is high; the input register
//   and the result register form a two-deep pipeline, each stage loading
//   when the stage after it is empty or draining.
// Reset: aresetn (synchronous, active low) empties both stages and sets
//   the phase index back to zero; no transaction in flight survives.
// Stall: with m_tready low the result holds, the input register fills,
//   and s_tready drops until the result is taken. Nothing is dropped.
// ----------------------------------------------------------------------------
module dual_sideband_frequency_shifter (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] in_re, [31:16] in_im
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: [15:0] up_re, [31:16] up_im, [47:32] down_re, [63:48] down_im
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata
);

    // stage 1: registered sample with its phasor
    logic              s1_valid_reg;
    logic              s1_valid_next;
    dsfs_pkg::cplx_t   s1_sample_reg;
    dsfs_pkg::phasor_t s1_phasor_reg;

    // stage 2: result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [63:0]       out_data_reg;

    logic              load_out;   // result register takes stage 1
    logic              load_s1;    // stage 1 can take a new sample
    logic              s_fire;

    dsfs_pkg::cplx_t   in_sample;
    dsfs_pkg::phasor_t cur_phasor;
    dsfs_pkg::cplx_t   up;
    dsfs_pkg::cplx_t   down;

    assign load_out = !out_valid_reg || m_tready;
    assign load_s1  = !s1_valid_reg || load_out;
    assign s_tready = load_s1;
    assign s_fire   = s_tvalid && load_s1;

    assign in_sample.re = s_tdata[15:0];
    assign in_sample.im = s_tdata[31:16];

    // phase only moves when a sample actually takes the phasor
    dsfs_phasor u_phasor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_fire),
        .phasor  (cur_phasor)
    );

    dsfs_mixer u_mixer (
        .sample (s1_sample_reg),
        .phasor (s1_phasor_reg),
        .up     (up),
        .down   (down)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (load_s1) begin
            s1_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = s1_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_sample_reg <= in_sample;
            s1_phasor_reg <= cur_phasor;
        end
        if (load_out && s1_valid_reg) begin
            out_data_reg <= {down.im, down.re, up.im, up.re};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/dsfs_phasor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfs_phasor
// Phase counter and table lookup: gives the phasor for the next sample.
// ----------------------------------------------------------------------------
module dsfs_phasor (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,   // a sample took the current phasor
    output dsfs_pkg::phasor_t phasor
);

    logic [dsfs_pkg::PHASE_W-1:0] phase_reg;
    logic [dsfs_pkg::PHASE_W-1:0] phase_next;

    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            if (phase_reg == dsfs_pkg::PHASE_W'(dsfs_pkg::PERIOD - 1)) begin
                phase_next = '0;
            end else begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    assign phasor = dsfs_pkg::phasor_lookup(phase_reg);

endmodule

// ===== design/dsfs_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfs_mixer
// Complex multiply by c+js and c-js, round and saturate both results.
// ----------------------------------------------------------------------------
module dsfs_mixer (
    input  dsfs_pkg::cplx_t   sample,
    input  dsfs_pkg::phasor_t phasor,
    output dsfs_pkg::cplx_t   up,
    output dsfs_pkg::cplx_t   down
);

    logic signed [dsfs_pkg::PROD_W-1:0] ac, bs, as_p, bc;
    logic signed [dsfs_pkg::SUM_W-1:0]  ac_x, bs_x, as_x, bc_x;

    assign ac   = sample.re * phasor.cos_v;
    assign bs   = sample.im * phasor.sin_v;
    assign as_p = sample.re * phasor.sin_v;
    assign bc   = sample.im * phasor.cos_v;

    assign ac_x = {ac[dsfs_pkg::PROD_W-1], ac};
    assign bs_x = {bs[dsfs_pkg::PROD_W-1], bs};
    assign as_x = {as_p[dsfs_pkg::PROD_W-1], as_p};
    assign bc_x = {bc[dsfs_pkg::PROD_W-1], bc};

    assign up.re   = dsfs_pkg::round_sat(ac_x - bs_x);
    assign up.im   = dsfs_pkg::round_sat(as_x + bc_x);
    assign down.re = dsfs_pkg::round_sat(ac_x + bs_x);
    assign down.im = dsfs_pkg::round_sat(bc_x - as_x);

endmodule

// ===== design/dsfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsfs_checker
// Port-level assertions for the dual-sideband shifter, bound to the top.
// ----------------------------------------------------------------------------
module dsfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // an empty output never backs up the input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    // a draining output keeps full rate
    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while output drains");

    // two samples in: output busy next cycle, input open only if it drains
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid && !m_tready |=>
            m_tvalid && (s_tready == m_tready))
        else $error("pipeline lost a sample under stall");

endmodule

bind dual_sideband_frequency_shifter dsfs_checker u_dsfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
